// File: hw/rtl/fcte_pkg.sv
// ----------------------------------------------------------------------------
// FAT chain table engine package
// Shared widths, codes and helper types for the link table engine.
// ----------------------------------------------------------------------------
package fcte_pkg;

   localparam int TABLE_ENTRIES_DEFAULT = 4096;

   localparam int MODE_WIDTH      = 3;
   localparam int LINK_WIDTH      = 16;
   localparam int STATUS_WIDTH    = 2;
   localparam int BLOCKS_WIDTH    = 6;
   localparam int SIZE_CODE_WIDTH = 3;
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = 6;
   localparam int ENTRY_COUNT_WIDTH = 17;
   localparam int BASE_SHIFT      = 7;

   localparam logic [LINK_WIDTH-1:0]      END_MARK      = 16'hFFFF;
   localparam logic [SIZE_CODE_WIDTH-1:0] SIZE_CODE_MAX = 3'd4;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BLOCKS_IN_TABLE = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BLOCK_SIZE_CODE = 1'b1;

   typedef enum logic [MODE_WIDTH-1:0] {
      MODE_READ   = 3'd0,
      MODE_FIND   = 3'd1,
      MODE_APPEND = 3'd2,
      MODE_FREE   = 3'd3,
      MODE_FORMAT = 3'd4
   } mode_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_RANGE = 2'd2,
      STATUS_LOOP  = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_WALK_CHECK,
      ST_WALK_DATA,
      ST_SEARCH,
      ST_LINK,
      ST_FREE_CHECK,
      ST_FREE_DATA,
      ST_FORMAT
   } state_type;

endpackage

// File: hw/rtl/fat_chain_table_engine_unit.sv
// ----------------------------------------------------------------------------
// FAT chain table engine
// Link table of next-block pointers with read, chain walk, append, free and
// format operations, held in one synchronous single-port-per-side memory.
// ----------------------------------------------------------------------------
// Usage: raise start with req_mode and req_index while busy is low; the item
// is taken at that edge and busy stays high until the answer is given; busy
// stays low for an out-of-range read or an unused mode. The answer sits on
// rsp_value, rsp_count and rsp_status for one cycle, marked by rsp_strobe;
// the receiver cannot hold it off. The csr_ port writes blocks_in_table
// (index 0) and block_size_code (index 1); the user must write them only
// while idle, as the block itself does not enforce it.
// Read entry answers from the table, or with a range status when out of range.
// Find chain walks links to the end mark; append walks likewise, scans for
// a free block and links it in, and a failed walk answers as find. Free chain
// clears links until the end or a free entry; format writes one table entry
// per cycle over the entries in use.
// The memory read is registered, and only one item is in work at a time.
// Reset clears the control state and the configuration (1 and 0); the table
// itself holds undefined contents until a format has run.
module fat_chain_table_engine_unit #(
   parameter int TABLE_ENTRIES = fcte_pkg::TABLE_ENTRIES_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [fcte_pkg::MODE_WIDTH-1:0]      req_mode,
   input  logic [fcte_pkg::LINK_WIDTH-1:0]      req_index,
   output logic                                 rsp_strobe,
   output logic [fcte_pkg::LINK_WIDTH-1:0]      rsp_value,
   output logic [fcte_pkg::LINK_WIDTH-1:0]      rsp_count,
   output logic [fcte_pkg::STATUS_WIDTH-1:0]    rsp_status,
   input  logic                                 csr_write_enable,
   input  logic [fcte_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [fcte_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data
);
   import fcte_pkg::*;

   localparam int AW = $clog2(TABLE_ENTRIES);
   localparam int NW = ENTRY_COUNT_WIDTH;
   localparam logic [NW-1:0] ENTRIES_MAX = NW'(TABLE_ENTRIES);

   logic [LINK_WIDTH-1:0] link_mem [TABLE_ENTRIES];
   logic [LINK_WIDTH-1:0] rd_data_ff;
   logic                  mem_rd_en;
   logic [AW-1:0]         mem_rd_addr;
   logic                  mem_wr_en;
   logic [AW-1:0]         mem_wr_addr;
   logic [LINK_WIDTH-1:0] mem_wr_data;

   logic [BLOCKS_WIDTH-1:0]    blocks_ff, blocks_in;
   logic [SIZE_CODE_WIDTH-1:0] size_code_ff, size_code_in;

   state_type state_ff, state_in;
   mode_type  op_ff, op_in;
   logic [LINK_WIDTH-1:0] cur_ff, cur_in;
   logic [NW-1:0]         cnt_ff, cnt_in;
   logic [NW-1:0]         scan_ff, scan_in;
   logic                  pend_ff, pend_in;
   logic [LINK_WIDTH-1:0] found_ff, found_in;

   logic                    rsp_strobe_ff, rsp_strobe_in;
   logic [LINK_WIDTH-1:0]   rsp_value_ff, rsp_value_in;
   logic [LINK_WIDTH-1:0]   rsp_count_ff, rsp_count_in;
   logic [STATUS_WIDTH-1:0] rsp_status_ff, rsp_status_in;

   logic [SIZE_CODE_WIDTH-1:0] size_code_eff;
   logic [NW-1:0]              entries_raw;
   logic [NW-1:0]              entries;
   logic [LINK_WIDTH-1:0]      header_word;
   logic                       accept;
   mode_type                   req_op;
   logic                       idx_out;
   logic                       cur_out;
   logic                       cur_stop;
   logic                       cnt_done;
   logic                       rd_is_end;
   logic                       rd_is_free;
   logic                       scan_done;
   logic                       fmt_done;

   always_comb begin
      size_code_eff = (size_code_ff > SIZE_CODE_MAX) ? SIZE_CODE_MAX : size_code_ff;
      entries_raw   = NW'(blocks_ff) << (BASE_SHIFT + int'(size_code_eff));
      entries       = (entries_raw > ENTRIES_MAX) ? ENTRIES_MAX : entries_raw;
      header_word   = {2'b00, blocks_ff, 5'b00000, size_code_ff};
      accept        = start && (state_ff == ST_IDLE);
      req_op        = mode_type'(req_mode);
      idx_out       = {1'b0, req_index} >= entries;
      cur_out       = {1'b0, cur_ff} >= entries;
      cur_stop      = (cur_ff == '0) || (cur_ff == END_MARK);
      cnt_done      = cnt_ff >= entries;
      rd_is_end     = rd_data_ff == END_MARK;
      rd_is_free    = rd_data_ff == '0;
      scan_done     = scan_ff >= entries;
      fmt_done      = scan_ff >= entries;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_op)
                  MODE_READ:   state_in = idx_out ? ST_IDLE : ST_READ;
                  MODE_FIND:   state_in = ST_WALK_CHECK;
                  MODE_APPEND: state_in = ST_WALK_CHECK;
                  MODE_FREE:   state_in = ST_FREE_CHECK;
                  MODE_FORMAT: state_in = ST_FORMAT;
                  default:     state_in = ST_IDLE;
               endcase
            end
         end
         ST_READ:       state_in = ST_IDLE;
         ST_WALK_CHECK: state_in = cur_out ? ST_IDLE : ST_WALK_DATA;
         ST_WALK_DATA: begin
            if (rd_is_end) begin
               state_in = (op_ff == MODE_APPEND) ? ST_SEARCH : ST_IDLE;
            end else if (cnt_done) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_WALK_CHECK;
            end
         end
         ST_SEARCH: begin
            if (pend_ff && rd_is_free) begin
               state_in = ST_LINK;
            end else if (scan_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_LINK:       state_in = ST_IDLE;
         ST_FREE_CHECK: state_in = (cur_stop || cur_out) ? ST_IDLE : ST_FREE_DATA;
         ST_FREE_DATA:  state_in = rd_is_free ? ST_IDLE : ST_FREE_CHECK;
         ST_FORMAT:     state_in = fmt_done ? ST_IDLE : ST_FORMAT;
         default:       state_in = ST_IDLE;
      endcase
   end

   // Datapath, memory access and results.
   always_comb begin
      blocks_in     = blocks_ff;
      size_code_in  = size_code_ff;
      op_in         = op_ff;
      cur_in        = cur_ff;
      cnt_in        = cnt_ff;
      scan_in       = scan_ff;
      pend_in       = 1'b0;
      found_in      = found_ff;
      rsp_strobe_in = 1'b0;
      rsp_value_in  = rsp_value_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_status_in = rsp_status_ff;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = cur_ff[AW-1:0];
      mem_wr_en     = 1'b0;
      mem_wr_addr   = cur_ff[AW-1:0];
      mem_wr_data   = '0;

      if (csr_write_enable) begin
         case (csr_index)
            CSR_BLOCKS_IN_TABLE: blocks_in = csr_write_data[BLOCKS_WIDTH-1:0];
            CSR_BLOCK_SIZE_CODE: size_code_in = csr_write_data[SIZE_CODE_WIDTH-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in   = req_op;
               cur_in  = req_index;
               cnt_in  = '0;
               scan_in = '0;
               case (req_op)
                  MODE_READ: begin
                     if (idx_out) begin
                        rsp_strobe_in = 1'b1;
                        rsp_value_in  = '0;
                        rsp_count_in  = '0;
                        rsp_status_in = STATUS_RANGE;
                     end else begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = req_index[AW-1:0];
                     end
                  end
                  MODE_FIND, MODE_APPEND, MODE_FREE, MODE_FORMAT: ;
                  default: begin
                     rsp_strobe_in = 1'b1;
                     rsp_value_in  = '0;
                     rsp_count_in  = '0;
                     rsp_status_in = STATUS_OK;
                  end
               endcase
            end
         end
         ST_READ: begin
            rsp_strobe_in = 1'b1;
            rsp_value_in  = rd_data_ff;
            rsp_count_in  = '0;
            rsp_status_in = STATUS_OK;
         end
         ST_WALK_CHECK: begin
            if (cur_out) begin
               rsp_strobe_in = 1'b1;
               rsp_value_in  = cur_ff;
               rsp_count_in  = cnt_ff[LINK_WIDTH-1:0];
               rsp_status_in = STATUS_RANGE;
            end else begin
               mem_rd_en = 1'b1;
            end
         end
         ST_WALK_DATA: begin
            if (rd_is_end) begin
               if (op_ff == MODE_APPEND) begin
                  scan_in = NW'(1);
               end else begin
                  rsp_strobe_in = 1'b1;
                  rsp_value_in  = cur_ff;
                  rsp_count_in  = cnt_ff[LINK_WIDTH-1:0];
                  rsp_status_in = STATUS_OK;
               end
            end else if (cnt_done) begin
               rsp_strobe_in = 1'b1;
               rsp_value_in  = cur_ff;
               rsp_count_in  = cnt_ff[LINK_WIDTH-1:0];
               rsp_status_in = STATUS_LOOP;
            end else begin
               cur_in = rd_data_ff;
               cnt_in = cnt_ff + NW'(1);
            end
         end
         ST_SEARCH: begin
            if (pend_ff && rd_is_free) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = cur_ff[AW-1:0];
               mem_wr_data = found_ff;
            end else if (scan_done) begin
               rsp_strobe_in = 1'b1;
               rsp_value_in  = '0;
               rsp_count_in  = cnt_ff[LINK_WIDTH-1:0];
               rsp_status_in = STATUS_FULL;
            end else begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = scan_ff[AW-1:0];
               pend_in     = 1'b1;
               found_in    = scan_ff[LINK_WIDTH-1:0];
               scan_in     = scan_ff + NW'(1);
            end
         end
         ST_LINK: begin
            mem_wr_en     = 1'b1;
            mem_wr_addr   = found_ff[AW-1:0];
            mem_wr_data   = END_MARK;
            rsp_strobe_in = 1'b1;
            rsp_value_in  = found_ff;
            rsp_count_in  = cnt_ff[LINK_WIDTH-1:0];
            rsp_status_in = STATUS_OK;
         end
         ST_FREE_CHECK: begin
            if (cur_stop) begin
               rsp_strobe_in = 1'b1;
               rsp_value_in  = '0;
               rsp_count_in  = cnt_ff[LINK_WIDTH-1:0];
               rsp_status_in = STATUS_OK;
            end else if (cur_out) begin
               rsp_strobe_in = 1'b1;
               rsp_value_in  = cur_ff;
               rsp_count_in  = cnt_ff[LINK_WIDTH-1:0];
               rsp_status_in = STATUS_RANGE;
            end else begin
               mem_rd_en = 1'b1;
            end
         end
         ST_FREE_DATA: begin
            if (rd_is_free) begin
               rsp_strobe_in = 1'b1;
               rsp_value_in  = '0;
               rsp_count_in  = cnt_ff[LINK_WIDTH-1:0];
               rsp_status_in = STATUS_OK;
            end else begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = cur_ff[AW-1:0];
               mem_wr_data = '0;
               cur_in      = rd_data_ff;
               cnt_in      = cnt_ff + NW'(1);
            end
         end
         ST_FORMAT: begin
            if (fmt_done) begin
               rsp_strobe_in = 1'b1;
               rsp_value_in  = header_word;
               rsp_count_in  = entries[LINK_WIDTH-1:0];
               rsp_status_in = STATUS_OK;
            end else begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = scan_ff[AW-1:0];
               if (scan_ff == NW'(0)) begin
                  mem_wr_data = header_word;
               end else if (scan_ff == NW'(1)) begin
                  mem_wr_data = END_MARK;
               end else begin
                  mem_wr_data = '0;
               end
               scan_in = scan_ff + NW'(1);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         link_mem[mem_wr_addr] <= mem_wr_data;
      end
      if (mem_rd_en) begin
         rd_data_ff <= link_mem[mem_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_strobe_ff <= 1'b0;
         pend_ff       <= 1'b0;
         blocks_ff     <= BLOCKS_WIDTH'(1);
         size_code_ff  <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
         pend_ff       <= pend_in;
         blocks_ff     <= blocks_in;
         size_code_ff  <= size_code_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      cur_ff        <= cur_in;
      cnt_ff        <= cnt_in;
      scan_ff       <= scan_in;
      found_ff      <= found_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign busy       = state_ff != ST_IDLE;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_count  = rsp_count_ff;
   assign rsp_status = rsp_status_ff;

endmodule
